// ===== rtl/safp_pkg.sv =====
// Shared types, sizes and codes for the sensor average frame packer.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package safp_pkg;

  // Channel counts and fixed-point format of the averages
  localparam int LOAD_CHANNELS = 6;
  localparam int IMU_CHANNELS  = 2;
  localparam int FRAC_BITS     = 16;
  localparam int TOT_CH        = LOAD_CHANNELS + IMU_CHANNELS;
  localparam int IDX_W         = (TOT_CH > 1) ? $clog2(TOT_CH) : 1;

  // Field widths
  localparam int CMD_W        = 2;
  localparam int CH_W         = 3;
  localparam int CHC_W        = CH_W + 1;
  localparam int SAMPLE_W     = 32;
  localparam int BYTE_W       = 8;
  localparam int BIDX_W       = 5;
  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 2;

  // Smoothing factor is unsigned Q0.16
  localparam int ALPHA_W      = 16;
  localparam int ALPHA_FRAC   = 16;

  // Average, difference magnitude and split multiply widths
  localparam int AVG_W        = SAMPLE_W + FRAC_BITS;
  localparam int DIFF_W       = AVG_W + 1;
  localparam int MAG_W        = AVG_W;
  localparam int LO_W         = 24;
  localparam int HI_W         = MAG_W - LO_W;
  localparam int PROD_W       = LO_W + ALPHA_W;
  localparam int SUM_W        = MAG_W + ALPHA_W + 1;

  // Frame layout
  localparam int LOAD_BYTES   = 2;
  localparam int IMU_BYTES    = 4;
  localparam int FRAME_LEN    = 2 + LOAD_BYTES * LOAD_CHANNELS + IMU_BYTES * IMU_CHANNELS;
  localparam int CNT_W        = $clog2(FRAME_LEN);
  localparam logic [BYTE_W-1:0] FRAME_MARK = 8'hAA;

  // Register reset values
  localparam logic [CFG_W-1:0] LOAD_ALPHA_RST = 16'd19661;
  localparam logic [CFG_W-1:0] IMU_ALPHA_RST  = 16'd6554;
  localparam logic [CFG_W-1:0] INTERVAL_RST   = 16'd13;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOAD_ALPHA = 2'd0,
    REG_IMU_ALPHA  = 2'd1,
    REG_INTERVAL   = 2'd2
  } reg_idx_t;

  // Request command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_IMU    = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_TXDONE = 2'd3
  } cmd_code_t;

  // Controller to datapath commands
  typedef struct packed {
    logic item_load;
    logic decode;
    logic mul_lo;
    logic mul_hi;
    logic acc;
    logic write;
    logic send_start;
    logic send_byte;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_sample;
    logic need_mul;
    logic send_ok;
    logic out_free;
    logic last;
  } ctrl_status_t;

endpackage

`default_nettype wire

// ===== rtl/safp_ctrl.sv =====
// Sequencing state machine of the frame packer.
// Depends on safp_pkg; drives commands into safp_datapath.
`default_nettype none

module safp_ctrl import safp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  ctrl_status_t status,
  output ctrl_cmd_t    ctl
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DECODE = 8'b0000_0010,
    ST_MUL_LO = 8'b0000_0100,
    ST_MUL_HI = 8'b0000_1000,
    ST_ACC    = 8'b0001_0000,
    ST_WRITE  = 8'b0010_0000,
    ST_CHECK  = 8'b0100_0000,
    ST_SEND   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Requests are taken only in idle
  assign in_stall = (state != ST_IDLE);

  // Command decode
  always_comb begin
    ctl            = '0;
    ctl.item_load  = (state == ST_IDLE) && in_valid;
    ctl.decode     = (state == ST_DECODE);
    ctl.mul_lo     = (state == ST_MUL_LO);
    ctl.mul_hi     = (state == ST_MUL_HI);
    ctl.acc        = (state == ST_ACC);
    ctl.write      = (state == ST_WRITE);
    ctl.send_start = (state == ST_CHECK) && status.send_ok;
    ctl.send_byte  = (state == ST_SEND) && status.out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (!status.is_sample) state_next = ST_CHECK;
        else if (status.need_mul) state_next = ST_MUL_LO;
        else state_next = ST_IDLE;
      end
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_ACC;
      ST_ACC:    state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_IDLE;
      ST_CHECK: begin
        state_next = status.send_ok ? ST_SEND : ST_IDLE;
      end
      ST_SEND: begin
        if (status.out_free && status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

`default_nettype wire

// ===== rtl/safp_datapath.sv =====
// Datapath: configuration registers, averages, split EMA multiply, frame byte
// generator and output register. Depends on safp_pkg; driven by safp_ctrl.
`default_nettype none

module safp_datapath import safp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  ctrl_cmd_t                  ctl,
  output ctrl_status_t               status,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic [CMD_W-1:0]           cmd,
  input  logic [CH_W-1:0]            channel,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       sensor_fault,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [BYTE_W-1:0]          frame_byte,
  output logic [BIDX_W-1:0]          byte_index,
  output logic                       last_byte
);

  // Configuration
  logic [ALPHA_W-1:0] load_alpha, imu_alpha;
  logic [CFG_W-1:0]   frame_interval_ms;

  // Block state
  logic [AVG_W-1:0]  avg_mem [TOT_CH];
  logic [TOT_CH-1:0] seen;
  logic              load_failed, imu_failed, link_busy;
  logic [15:0]       elapsed_ms;

  // Held request
  cmd_code_t                cmd_q;
  logic [CH_W-1:0]          ch_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                     fault_q;

  // Update pipeline registers
  logic [AVG_W-1:0]  avg_q;
  logic              neg_q;
  logic [MAG_W-1:0]  mag_q;
  logic [PROD_W-1:0] prod_lo, prod_hi;
  logic [SUM_W-1:0]  sum_q;

  // Frame walk
  logic [CNT_W-1:0] bcnt;
  logic [IDX_W-1:0] ch_ptr;
  logic [1:0]       byte_sel;

  // Request decode
  logic             is_load, is_imu, ch_valid, grp_failed, upd_ok;
  logic [IDX_W-1:0] item_idx, rd_idx;
  logic signed [SAMPLE_W-1:0] x32;
  logic [AVG_W-1:0] target, avg_rd;
  logic [DIFF_W-1:0] diff, diff_abs;
  logic              diff_neg;
  logic [ALPHA_W-1:0] alpha;

  assign is_load  = (cmd_q == CMD_LOAD);
  assign is_imu   = (cmd_q == CMD_IMU);
  assign ch_valid = is_load ? ({1'b0, ch_q} < CHC_W'(LOAD_CHANNELS))
                            : ({1'b0, ch_q} < CHC_W'(IMU_CHANNELS));
  assign item_idx = is_load ? IDX_W'(ch_q) : IDX_W'(LOAD_CHANNELS) + IDX_W'(ch_q);
  assign grp_failed = is_load ? load_failed : imu_failed;
  assign upd_ok   = (is_load || is_imu) && !grp_failed && !fault_q && ch_valid;
  assign alpha    = is_imu ? imu_alpha : load_alpha;

  // Load samples saturate to int16
  always_comb begin
    x32 = sample_q;
    if (is_load) begin
      if (sample_q > 32'sd32767)       x32 = 32'sd32767;
      else if (sample_q < -32'sd32768) x32 = -32'sd32768;
    end
  end

  assign target = {x32, {FRAC_BITS{1'b0}}};

  // Single read port on the averages
  assign rd_idx = ctl.decode ? item_idx : ch_ptr;
  assign avg_rd = avg_mem[rd_idx];

  // Difference and its magnitude
  assign diff     = {target[AVG_W-1], target} - {avg_rd[AVG_W-1], avg_rd};
  assign diff_neg = diff[DIFF_W-1];
  assign diff_abs = diff_neg ? (~diff + 1'b1) : diff;

  // Shared 24x16 multiplier, low half then high half of the magnitude
  logic [LO_W-1:0]   mul_a;
  logic [PROD_W-1:0] mul_p;
  assign mul_a = ctl.mul_hi ? LO_W'(mag_q[MAG_W-1:LO_W]) : mag_q[LO_W-1:0];
  assign mul_p = PROD_W'(mul_a) * PROD_W'(alpha);

  // Rounding: downward moves use the ceiling of the scaled product
  localparam logic [SUM_W-1:0] RND = SUM_W'((1 << ALPHA_FRAC) - 1);
  logic [MAG_W-1:0] step;
  logic [AVG_W-1:0] avg_new;
  assign step    = sum_q[ALPHA_FRAC +: MAG_W];
  assign avg_new = neg_q ? (avg_q - AVG_W'(step)) : (avg_q + AVG_W'(step));

  // Frame byte generation: truncate toward zero, pick byte
  localparam logic [AVG_W-1:0] TRUNC_RND = AVG_W'((1 << FRAC_BITS) - 1);
  logic [AVG_W-1:0]    trunc_sum;
  logic [31:0]         word;
  logic                ptr_load, ptr_failed, mark, ch_last_byte;
  logic [BYTE_W-1:0]   data_byte, next_byte;

  assign trunc_sum    = avg_rd + (avg_rd[AVG_W-1] ? TRUNC_RND : '0);
  assign ptr_load     = (32'(ch_ptr) < LOAD_CHANNELS);
  assign ptr_failed   = ptr_load ? load_failed : imu_failed;
  assign word         = ptr_failed ? 32'd0 : trunc_sum[FRAC_BITS +: 32];
  assign data_byte    = word[8*byte_sel +: 8];
  assign mark         = (bcnt == '0) || (bcnt == CNT_W'(FRAME_LEN - 1));
  assign next_byte    = mark ? FRAME_MARK : data_byte;
  assign ch_last_byte = ptr_load ? (byte_sel == 2'(LOAD_BYTES - 1))
                                 : (byte_sel == 2'(IMU_BYTES - 1));

  // Status
  always_comb begin
    status           = '0;
    status.is_sample = is_load || is_imu;
    status.need_mul  = upd_ok && seen[item_idx];
    status.send_ok   = (elapsed_ms > frame_interval_ms) && !link_busy;
    status.out_free  = !out_valid || !out_stall;
    status.last      = (bcnt == CNT_W'(FRAME_LEN - 1));
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      load_alpha        <= LOAD_ALPHA_RST;
      imu_alpha         <= IMU_ALPHA_RST;
      frame_interval_ms <= INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOAD_ALPHA: load_alpha        <= cfg_data;
        REG_IMU_ALPHA:  imu_alpha         <= cfg_data;
        REG_INTERVAL:   frame_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      cmd_q    <= cmd_code_t'(cmd);
      ch_q     <= channel;
      sample_q <= sample;
      fault_q  <= sensor_fault;
    end
  end

  // Multiply and accumulate registers
  always_ff @(posedge clk) begin
    if (ctl.decode) begin
      avg_q <= avg_rd;
      neg_q <= diff_neg;
      mag_q <= diff_abs[MAG_W-1:0];
    end
    if (ctl.mul_lo) prod_lo <= mul_p;
    if (ctl.mul_hi) prod_hi <= mul_p;
    if (ctl.acc) begin
      sum_q <= (SUM_W'(prod_hi) << LO_W) + SUM_W'(prod_lo) + (neg_q ? RND : '0);
    end
  end

  // Averages, flags, timer and link state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOT_CH; i++) avg_mem[i] <= '0;
      seen        <= '0;
      load_failed <= 1'b0;
      imu_failed  <= 1'b0;
      link_busy   <= 1'b0;
      elapsed_ms  <= '0;
    end else begin
      if (ctl.decode) begin
        if (is_load && fault_q) load_failed <= 1'b1;
        if (is_imu && fault_q)  imu_failed  <= 1'b1;
        // first sample of a channel loads directly
        if (upd_ok && !seen[item_idx]) begin
          avg_mem[item_idx] <= target;
          seen[item_idx]    <= 1'b1;
        end
        if (cmd_q == CMD_TICK && elapsed_ms != 16'hFFFF) elapsed_ms <= elapsed_ms + 16'd1;
        if (cmd_q == CMD_TXDONE) link_busy <= 1'b0;
      end
      if (ctl.write) avg_mem[item_idx] <= avg_new;
      if (ctl.send_start) begin
        link_busy  <= 1'b1;
        elapsed_ms <= '0;
      end
    end
  end

  // Frame walk pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt     <= '0;
      ch_ptr   <= '0;
      byte_sel <= '0;
    end else if (ctl.send_start) begin
      bcnt     <= '0;
      ch_ptr   <= '0;
      byte_sel <= '0;
    end else if (ctl.send_byte) begin
      bcnt <= bcnt + 1'b1;
      if (!mark) begin
        if (ch_last_byte) begin
          byte_sel <= '0;
          if (ch_ptr != IDX_W'(TOT_CH - 1)) ch_ptr <= ch_ptr + 1'b1;
        end else begin
          byte_sel <= byte_sel + 2'd1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.send_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.send_byte) begin
      frame_byte <= next_byte;
      byte_index <= BIDX_W'(bcnt);
      last_byte  <= status.last;
    end
  end

  // Sending a frame marks the link busy and restarts the timer
  a_send_start: assert property (@(posedge clk) disable iff (rst)
    ctl.send_start |=> link_busy && (elapsed_ms == '0))
    else $error("send start did not set link busy / clear timer");

  // The closing byte is always the end marker at the final position
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte) |->
      (frame_byte == FRAME_MARK) && (byte_index == BIDX_W'(FRAME_LEN - 1)))
    else $error("last byte is not the end marker");

  // Channel pointer never walks past the last channel
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ch_ptr <= IDX_W'(TOT_CH - 1))
    else $error("channel pointer out of range");

  // A byte is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !ctl.send_byte)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/sensor_average_frame_packer.sv =====
// Sensor average frame packer: top level joining controller and datapath.
// Depends on safp_pkg, safp_ctrl and safp_datapath.
//
// Usage:
//   Requests enter on in_valid/in_stall with cmd, channel, sample and
//   sensor_fault. cmd selects a load-cell sample, an IMU sample, a
//   millisecond tick or a transmit-done event. Samples update the moving
//   average of their channel; ticks and transmit-done may start a frame.
//   Frame bytes leave on out_valid/out_stall, one byte at a time, with
//   byte_index and last_byte flagging the closing marker.
//   Flow: after acceptance a sample goes back to idle from decode when it is
//   the first of its channel (or ignored); otherwise the 48x16 product is formed
//   in two passes through one 24x16 multiplier, then accumulated and written.
//   Tick and transmit-done are decoded and checked, and when a frame goes out
//   its 22 bytes are walked in order while the receiver does not stall.
//   The output register lets the next request enter while the last byte waits.
//   A stalled receiver freezes the current byte and pauses the frame walk.
//   Reset (rst, synchronous) restores register defaults, clears averages,
//   fault flags, timer and link state. Configuration writes on cfg_we take
//   effect at once and are meant for idle periods.
`default_nettype none

module sensor_average_frame_packer import safp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           cmd,
  input  logic [CH_W-1:0]            channel,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       sensor_fault,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [BYTE_W-1:0]          frame_byte,
  output logic [BIDX_W-1:0]          byte_index,
  output logic                       last_byte
);

  ctrl_cmd_t    ctl;
  ctrl_status_t status;

  safp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .ctl      (ctl)
  );

  safp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .channel      (channel),
    .sample       (sample),
    .sensor_fault (sensor_fault),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_byte   (frame_byte),
    .byte_index   (byte_index),
    .last_byte    (last_byte)
  );

endmodule

`default_nettype wire
